// ----- src/ppp_pkg.sv -----
// Shared types and constants for the perspective point projector.
// Used by every module of the block; no dependencies.
package ppp_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   localparam int PT_W    = 20;
   localparam int DIF_W   = PT_W + 1;
   localparam int ENT_W   = 16;
   localparam int PRD_W   = ENT_W + DIF_W;
   localparam int CAM_W   = PRD_W + 2;
   localparam int DIST_W  = 19;
   localparam int DSG_W   = DIST_W + 1;
   localparam int LO_W    = 20;
   localparam int HI_W    = CAM_W - LO_W;
   localparam int PPL_W   = DSG_W + LO_W + 1;
   localparam int PPH_W   = DSG_W + HI_W;
   localparam int SCL_W   = 59;
   localparam int SUM_W   = SCL_W + 1;
   localparam int A_W     = 58;
   localparam int DEN_W   = A_W + 1;
   localparam int ASPL_W  = A_W / 2;
   localparam int DEPTH_SHIFT = 14;

   localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int Q_W     = $clog2(SCREEN_MAX);
   localparam int MP_W    = ASPL_W + Q_W;
   localparam int N_W     = A_W + Q_W + 2;
   localparam int DIV_EN_W = Q_W + 2;
   localparam int NUM_STAGES = Q_W + 9;

   localparam int COL_W   = 10;
   localparam int ROW_W   = 9;
   localparam int ADDR_W  = 6;
   localparam int DATA_W  = 64;
   localparam int ROW_REG_W = 48;
   localparam int ORG_W   = 60;

   typedef enum logic [2:0] {
      CSR_BASIS_ROW_ZERO   = 3'd0,
      CSR_BASIS_ROW_ONE    = 3'd1,
      CSR_BASIS_ROW_TWO    = 3'd2,
      CSR_CAMERA_ORIGIN    = 3'd3,
      CSR_NEAR_DISTANCE    = 3'd4,
      CSR_FAR_DISTANCE     = 3'd5,
      CSR_HALF_VIEW_WIDTH  = 3'd6,
      CSR_HALF_VIEW_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ROW_REG_W-1:0] basis0;
      logic [ROW_REG_W-1:0] basis1;
      logic [ROW_REG_W-1:0] basis2;
      logic [ORG_W-1:0]     origin;
      logic [DIST_W-1:0]    near;
      logic [DIST_W-1:0]    far;
      logic [DIST_W-1:0]    half_w;
      logic [DIST_W-1:0]    half_h;
   } cfg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

// ----- src/ppp_if.sv -----
// Handshake interfaces for the point and result words.
// Depends on ppp_pkg for field widths.
interface ppp_req_if;
   logic valid;
   logic ready;
   logic signed [ppp_pkg::PT_W-1:0] point_x;
   logic signed [ppp_pkg::PT_W-1:0] point_y;
   logic signed [ppp_pkg::PT_W-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_rsp_if;
   logic valid;
   logic ready;
   logic visible;
   logic [ppp_pkg::COL_W-1:0] pixel_column;
   logic [ppp_pkg::ROW_W-1:0] pixel_row;
   modport source (output valid, visible, pixel_column, pixel_row, input ready);
   modport sink (input valid, visible, pixel_column, pixel_row, output ready);
endinterface

// ----- src/ppp_csr.sv -----
// Configuration registers behind the APB-style write/read port.
// Depends on ppp_pkg.
module ppp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ppp_pkg::ADDR_W-1:0]  paddr,
   input  logic [ppp_pkg::DATA_W-1:0]  pwdata,
   output logic [ppp_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output ppp_pkg::cfg_type            cfg
);
   ppp_pkg::cfg_type       cfg_ff;
   ppp_pkg::csr_index_type idx;
   logic                   wr;

   assign idx    = ppp_pkg::csr_index_type'(paddr[ppp_pkg::ADDR_W-1:3]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.basis0 <= ppp_pkg::ROW_REG_W'(48'd16384);
         cfg_ff.basis1 <= ppp_pkg::ROW_REG_W'(48'd1073741824);
         cfg_ff.basis2 <= ppp_pkg::ROW_REG_W'(48'd70368744177664);
         cfg_ff.origin <= '0;
         cfg_ff.near   <= ppp_pkg::DIST_W'(256);
         cfg_ff.far    <= ppp_pkg::DIST_W'(25600);
         cfg_ff.half_w <= ppp_pkg::DIST_W'(256);
         cfg_ff.half_h <= ppp_pkg::DIST_W'(192);
      end else if (wr) begin
         case (idx)
            ppp_pkg::CSR_BASIS_ROW_ZERO:   cfg_ff.basis0 <= pwdata[ppp_pkg::ROW_REG_W-1:0];
            ppp_pkg::CSR_BASIS_ROW_ONE:    cfg_ff.basis1 <= pwdata[ppp_pkg::ROW_REG_W-1:0];
            ppp_pkg::CSR_BASIS_ROW_TWO:    cfg_ff.basis2 <= pwdata[ppp_pkg::ROW_REG_W-1:0];
            ppp_pkg::CSR_CAMERA_ORIGIN:    cfg_ff.origin <= pwdata[ppp_pkg::ORG_W-1:0];
            ppp_pkg::CSR_NEAR_DISTANCE:    cfg_ff.near   <= pwdata[ppp_pkg::DIST_W-1:0];
            ppp_pkg::CSR_FAR_DISTANCE:     cfg_ff.far    <= pwdata[ppp_pkg::DIST_W-1:0];
            ppp_pkg::CSR_HALF_VIEW_WIDTH:  cfg_ff.half_w <= pwdata[ppp_pkg::DIST_W-1:0];
            ppp_pkg::CSR_HALF_VIEW_HEIGHT: cfg_ff.half_h <= pwdata[ppp_pkg::DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         ppp_pkg::CSR_BASIS_ROW_ZERO:   prdata = ppp_pkg::DATA_W'(cfg_ff.basis0);
         ppp_pkg::CSR_BASIS_ROW_ONE:    prdata = ppp_pkg::DATA_W'(cfg_ff.basis1);
         ppp_pkg::CSR_BASIS_ROW_TWO:    prdata = ppp_pkg::DATA_W'(cfg_ff.basis2);
         ppp_pkg::CSR_CAMERA_ORIGIN:    prdata = ppp_pkg::DATA_W'(cfg_ff.origin);
         ppp_pkg::CSR_NEAR_DISTANCE:    prdata = ppp_pkg::DATA_W'(cfg_ff.near);
         ppp_pkg::CSR_FAR_DISTANCE:     prdata = ppp_pkg::DATA_W'(cfg_ff.far);
         ppp_pkg::CSR_HALF_VIEW_WIDTH:  prdata = ppp_pkg::DATA_W'(cfg_ff.half_w);
         ppp_pkg::CSR_HALF_VIEW_HEIGHT: prdata = ppp_pkg::DATA_W'(cfg_ff.half_h);
         default:                       prdata = '0;
      endcase
   end
endmodule

// ----- src/ppp_ctrl.sv -----
// Pipeline valid bits and per-stage load enables with a ready chain.
// Depends on ppp_pkg.
module ppp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ppp_pkg::pipe_ctl_type ctl
);
   localparam int NS = ppp_pkg::NUM_STAGES;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] rdy;

   always_comb begin
      rdy[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.load  = rdy;
   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[NS-1];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NS-1] && !out_ready |=> vld_ff[NS-1])
      else $error("stalled result word dropped");
endmodule

// ----- src/ppp_transform.sv -----
// World to camera transform: origin subtract, products, row sums.
// Three stages; depends on ppp_pkg.
module ppp_transform (
   input  logic                                clock,
   input  logic [2:0]                          load,
   input  logic signed [ppp_pkg::PT_W-1:0]     point_x,
   input  logic signed [ppp_pkg::PT_W-1:0]     point_y,
   input  logic signed [ppp_pkg::PT_W-1:0]     point_z,
   input  ppp_pkg::cfg_type                    cfg,
   output logic signed [ppp_pkg::CAM_W-1:0]    cam_x,
   output logic signed [ppp_pkg::CAM_W-1:0]    cam_y,
   output logic signed [ppp_pkg::CAM_W-1:0]    cam_z
);
   logic signed [ppp_pkg::PT_W-1:0]  pt [3];
   logic signed [ppp_pkg::PT_W-1:0]  org [3];
   logic [ppp_pkg::ROW_REG_W-1:0]    basis [3];
   logic signed [ppp_pkg::DIF_W-1:0] dif_ff [3];
   logic signed [ppp_pkg::PRD_W-1:0] prd_ff [3][3];
   logic signed [ppp_pkg::CAM_W-1:0] cam_ff [3];

   always_comb begin
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
      basis[0] = cfg.basis0;
      basis[1] = cfg.basis1;
      basis[2] = cfg.basis2;
      for (int j = 0; j < 3; j++) begin
         org[j] = $signed(cfg.origin[ppp_pkg::PT_W*j +: ppp_pkg::PT_W]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         if (load[0]) dif_ff[j] <= ppp_pkg::DIF_W'(pt[j]) - ppp_pkg::DIF_W'(org[j]);
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (load[1]) begin
               prd_ff[i][j] <=
                  ppp_pkg::PRD_W'($signed(basis[i][ppp_pkg::ENT_W*j +: ppp_pkg::ENT_W]))
                  * ppp_pkg::PRD_W'(dif_ff[j]);
            end
         end
         if (load[2]) begin
            cam_ff[i] <= ppp_pkg::CAM_W'(prd_ff[i][0]) + ppp_pkg::CAM_W'(prd_ff[i][1])
                         + ppp_pkg::CAM_W'(prd_ff[i][2]);
         end
      end
   end

   assign cam_x = cam_ff[0];
   assign cam_y = cam_ff[1];
   assign cam_z = cam_ff[2];
endmodule

// ----- src/ppp_clip.sv -----
// Perspective scaling and frustum test by cross-multiplication.
// Three stages; depends on ppp_pkg.
module ppp_clip (
   input  logic                              clock,
   input  logic [2:0]                        load,
   input  logic signed [ppp_pkg::CAM_W-1:0]  cam_x,
   input  logic signed [ppp_pkg::CAM_W-1:0]  cam_y,
   input  logic signed [ppp_pkg::CAM_W-1:0]  cam_z,
   input  ppp_pkg::cfg_type                  cfg,
   output logic [ppp_pkg::A_W-1:0]           num_x,
   output logic [ppp_pkg::A_W-1:0]           den_x,
   output logic [ppp_pkg::A_W-1:0]           num_z,
   output logic [ppp_pkg::A_W-1:0]           den_z,
   output logic                              visible
);
   localparam int LW = ppp_pkg::LO_W;
   localparam int CW = ppp_pkg::CAM_W;

   logic signed [ppp_pkg::DSG_W-1:0] mul_a [4];
   logic signed [CW-1:0]             mul_b [4];
   logic signed [ppp_pkg::PPL_W-1:0] ppl_ff [4];
   logic signed [ppp_pkg::PPH_W-1:0] pph_ff [4];
   logic signed [ppp_pkg::SCL_W-1:0] scl_ff [4];
   logic signed [CW-1:0]             near_q;
   logic signed [CW-1:0]             far_q;
   logic                             depth_ok_ff;
   logic                             depth_ok2_ff;
   logic signed [ppp_pkg::SUM_W-1:0] sum_x, dif_x, sum_z, dif_z;
   logic [ppp_pkg::A_W-1:0]          num_x_ff, den_x_ff, num_z_ff, den_z_ff;
   logic                             vis_ff;

   always_comb begin
      mul_a[0] = $signed({1'b0, cfg.near});
      mul_a[1] = $signed({1'b0, cfg.near});
      mul_a[2] = $signed({1'b0, cfg.half_w});
      mul_a[3] = $signed({1'b0, cfg.half_h});
      mul_b[0] = cam_x;
      mul_b[1] = cam_z;
      mul_b[2] = cam_y;
      mul_b[3] = cam_y;
      near_q = $signed(CW'({cfg.near, {ppp_pkg::DEPTH_SHIFT{1'b0}}}));
      far_q  = $signed(CW'({cfg.far, {ppp_pkg::DEPTH_SHIFT{1'b0}}}));
      sum_x = ppp_pkg::SUM_W'(scl_ff[0]) + ppp_pkg::SUM_W'(scl_ff[2]);
      dif_x = ppp_pkg::SUM_W'(scl_ff[2]) - ppp_pkg::SUM_W'(scl_ff[0]);
      sum_z = ppp_pkg::SUM_W'(scl_ff[1]) + ppp_pkg::SUM_W'(scl_ff[3]);
      dif_z = ppp_pkg::SUM_W'(scl_ff[3]) - ppp_pkg::SUM_W'(scl_ff[1]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (load[0]) begin
            ppl_ff[k] <= ppp_pkg::PPL_W'(mul_a[k])
                         * ppp_pkg::PPL_W'($signed({1'b0, mul_b[k][LW-1:0]}));
            pph_ff[k] <= ppp_pkg::PPH_W'(mul_a[k]) * ppp_pkg::PPH_W'($signed(mul_b[k][CW-1:LW]));
         end
         if (load[1]) begin
            scl_ff[k] <= (ppp_pkg::SCL_W'(pph_ff[k]) <<< LW) + ppp_pkg::SCL_W'(ppl_ff[k]);
         end
      end
      if (load[0]) depth_ok_ff <= (cam_y > 0) && (cam_y >= near_q) && (cam_y <= far_q);
      if (load[1]) depth_ok2_ff <= depth_ok_ff;
      if (load[2]) begin
         num_x_ff <= sum_x[ppp_pkg::A_W-1:0];
         den_x_ff <= {scl_ff[2][ppp_pkg::A_W-2:0], 1'b0};
         num_z_ff <= sum_z[ppp_pkg::A_W-1:0];
         den_z_ff <= {scl_ff[3][ppp_pkg::A_W-2:0], 1'b0};
         vis_ff   <= depth_ok2_ff && (cfg.half_w != '0) && (cfg.half_h != '0)
                     && !sum_x[ppp_pkg::SUM_W-1] && !dif_x[ppp_pkg::SUM_W-1]
                     && !sum_z[ppp_pkg::SUM_W-1] && !dif_z[ppp_pkg::SUM_W-1];
      end
   end

   assign num_x   = num_x_ff;
   assign den_x   = den_x_ff;
   assign num_z   = num_z_ff;
   assign den_z   = den_z_ff;
   assign visible = vis_ff;
endmodule

// ----- src/ppp_divider.sv -----
// Rounded scale-and-divide: round_half_up(num*mult/den) as a pipelined
// restoring division, one quotient bit per stage. Depends on ppp_pkg.
module ppp_divider (
   input  logic                               clock,
   input  logic [ppp_pkg::DIV_EN_W-1:0]       load,
   input  logic [ppp_pkg::A_W-1:0]            num,
   input  logic [ppp_pkg::A_W-1:0]            den,
   input  logic [ppp_pkg::Q_W-1:0]            mult,
   output logic [ppp_pkg::Q_W-1:0]            quo
);
   localparam int QW = ppp_pkg::Q_W;
   localparam int NW = ppp_pkg::N_W;
   localparam int SW = ppp_pkg::ASPL_W;

   logic [ppp_pkg::MP_W-1:0]    plo_ff, phi_ff;
   logic [ppp_pkg::A_W-1:0]     dq_ff;
   logic [NW-1:0]               rem_ff [QW];
   logic [ppp_pkg::DEN_W-1:0]   dv_ff [QW];
   logic [QW-1:0]               quo_ff [QW+1];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         plo_ff <= ppp_pkg::MP_W'(num[SW-1:0]) * ppp_pkg::MP_W'(mult);
         phi_ff <= ppp_pkg::MP_W'(num[ppp_pkg::A_W-1:SW]) * ppp_pkg::MP_W'(mult);
         dq_ff  <= den;
      end
      if (load[1]) begin
         rem_ff[0] <= NW'({(NW'({phi_ff, {SW{1'b0}}}) + NW'(plo_ff)), 1'b0}) + NW'(dq_ff);
         dv_ff[0]  <= {dq_ff, 1'b0};
         quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [NW-1:0] shifted;
      logic          take;
      assign shifted = NW'(dv_ff[k]) << (QW - 1 - k);
      assign take    = rem_ff[k] >= shifted;
      always_ff @(posedge clock) begin
         if (load[k+2]) quo_ff[k+1] <= (quo_ff[k] << 1) | QW'(take);
      end
      if (k < QW - 1) begin : g_mid
         always_ff @(posedge clock) begin
            if (load[k+2]) begin
               rem_ff[k+1] <= take ? rem_ff[k] - shifted : rem_ff[k];
               dv_ff[k+1]  <= dv_ff[k];
            end
         end
      end
   end

   assign quo = quo_ff[QW];
endmodule

// ----- src/perspective_point_projector.sv -----
// Pipeline stages from an accepted point word to its result word
// (transform 3, clip 3, scale 2, one stage per quotient bit 10, output 1).
// Throughput: one word per cycle; each stage holds only while its successor
// is full and stalled. Reset clears all valid bits and restores the
// configuration registers to their defaults.
// Top level; depends on ppp_pkg, ppp_if and the ppp_* modules.
module perspective_point_projector (
   input  logic                          clock,
   input  logic                          reset,
   ppp_req_if.sink                       req,
   ppp_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ppp_pkg::ADDR_W-1:0]    paddr,
   input  logic [ppp_pkg::DATA_W-1:0]    pwdata,
   output logic [ppp_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   localparam int QW   = ppp_pkg::Q_W;
   localparam int LAST = ppp_pkg::NUM_STAGES - 1;
   localparam int VP   = QW + 2;

   ppp_pkg::cfg_type                 cfg;
   ppp_pkg::pipe_ctl_type            ctl;
   logic signed [ppp_pkg::CAM_W-1:0] cam_x, cam_y, cam_z;
   logic [ppp_pkg::A_W-1:0]          num_x, den_x, num_z, den_z;
   logic                             clip_vis;
   logic [QW-1:0]                    quo_x, quo_z;
   logic                             vis_ff [VP];
   logic                             out_vis_ff;
   logic [ppp_pkg::COL_W-1:0]        col_ff;
   logic [ppp_pkg::ROW_W-1:0]        row_ff;
   logic [QW-1:0]                    up_row;

   ppp_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
   );

   ppp_ctrl u_ctrl (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .ctl
   );

   ppp_transform u_xform (
      .clock, .load(ctl.load[2:0]),
      .point_x(req.point_x), .point_y(req.point_y), .point_z(req.point_z),
      .cfg, .cam_x, .cam_y, .cam_z
   );

   ppp_clip u_clip (
      .clock, .load(ctl.load[5:3]), .cam_x, .cam_y, .cam_z, .cfg,
      .num_x, .den_x, .num_z, .den_z, .visible(clip_vis)
   );

   ppp_divider u_div_x (
      .clock, .load(ctl.load[LAST-1:6]), .num(num_x), .den(den_x),
      .mult(QW'(ppp_pkg::SCREEN_WIDTH - 1)), .quo(quo_x)
   );

   ppp_divider u_div_z (
      .clock, .load(ctl.load[LAST-1:6]), .num(num_z), .den(den_z),
      .mult(QW'(ppp_pkg::SCREEN_HEIGHT - 1)), .quo(quo_z)
   );

   assign up_row = QW'(ppp_pkg::SCREEN_HEIGHT - 1) - quo_z;

   always_ff @(posedge clock) begin
      if (ctl.load[6]) vis_ff[0] <= clip_vis;
      for (int k = 1; k < VP; k++) begin
         if (ctl.load[6+k]) vis_ff[k] <= vis_ff[k-1];
      end
      if (ctl.load[LAST]) begin
         out_vis_ff <= vis_ff[VP-1];
         col_ff     <= vis_ff[VP-1] ? ppp_pkg::COL_W'(quo_x) : '0;
         row_ff     <= vis_ff[VP-1] ? ppp_pkg::ROW_W'(up_row) : '0;
      end
   end

   assign rsp.visible      = out_vis_ff;
   assign rsp.pixel_column = col_ff;
   assign rsp.pixel_row    = row_ff;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.visible |-> rsp.pixel_column == '0 && rsp.pixel_row == '0)
      else $error("invisible word carries a pixel");
   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.visible |->
         rsp.pixel_column <= ppp_pkg::COL_W'(ppp_pkg::SCREEN_WIDTH - 1)
         && rsp.pixel_row <= ppp_pkg::ROW_W'(ppp_pkg::SCREEN_HEIGHT - 1))
      else $error("visible pixel off screen");
endmodule

// ----- sim/ppp_checker.sv -----
// Checker for the perspective point projector: tracks register writes, predicts
// one result word per accepted point word and compares in order.
// Depends on ppp_pkg and the ppp_req_if / ppp_rsp_if interfaces.
module ppp_checker
   import ppp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ppp_req_if                req,
   ppp_rsp_if                rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   input  logic              pready,
   output int                mismatches,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             visible;
      logic [COL_W-1:0] pixel_column;
      logic [ROW_W-1:0] pixel_row;
   } pixel_word_type;

   cfg_type        view;
   pixel_word_type pixels_due[$];

   function automatic longint unsigned round_scaled(input longint unsigned a,
                                                    input longint unsigned den,
                                                    input int mult);
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] rem;
      prod = 128'(a) * 128'(mult);
      quo = prod / 128'(den);
      rem = prod % 128'(den);
      if (2 * rem >= 128'(den)) quo = quo + 1;
      return quo[63:0];
   endfunction

   function automatic pixel_word_type project(input logic signed [PT_W-1:0] px,
                                              input logic signed [PT_W-1:0] py,
                                              input logic signed [PT_W-1:0] pz);
      logic [ROW_REG_W-1:0] rows [3];
      longint diff [3];
      longint cam [3];
      longint n, f, r, t, ax, az;
      longint unsigned col, up;
      pixel_word_type w;
      rows[0] = view.basis0;
      rows[1] = view.basis1;
      rows[2] = view.basis2;
      diff[0] = longint'(px) - longint'($signed(view.origin[19:0]));
      diff[1] = longint'(py) - longint'($signed(view.origin[39:20]));
      diff[2] = longint'(pz) - longint'($signed(view.origin[59:40]));
      for (int i = 0; i < 3; i++) begin
         cam[i] = 0;
         for (int j = 0; j < 3; j++)
            cam[i] += longint'($signed(rows[i][16*j +: 16])) * diff[j];
      end
      n = longint'(view.near);
      f = longint'(view.far);
      r = longint'(view.half_w);
      t = longint'(view.half_h);
      ax = n * cam[0];
      az = n * cam[2];
      if (ax < 0) ax = -ax;
      if (az < 0) az = -az;
      w = '0;
      if (cam[1] > 0 && r > 0 && t > 0 && cam[1] >= n * 16384 && cam[1] <= f * 16384
          && ax <= r * cam[1] && az <= t * cam[1]) begin
         col = round_scaled(n * cam[0] + r * cam[1], 2 * r * cam[1], SCREEN_WIDTH - 1);
         up = round_scaled(n * cam[2] + t * cam[1], 2 * t * cam[1], SCREEN_HEIGHT - 1);
         w.visible = 1'b1;
         w.pixel_column = col[COL_W-1:0];
         w.pixel_row = ROW_W'(longint'(SCREEN_HEIGHT - 1) - longint'(up));
      end
      return w;
   endfunction

   always @(posedge clock) begin
      pixel_word_type want;
      if (reset) begin
         view.basis0 <= 48'd16384;
         view.basis1 <= 48'd1073741824;
         view.basis2 <= 48'd70368744177664;
         view.origin <= '0;
         view.near <= 19'd256;
         view.far <= 19'd25600;
         view.half_w <= 19'd256;
         view.half_h <= 19'd192;
         pixels_due.delete();
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[5:3]))
               CSR_BASIS_ROW_ZERO:   view.basis0 <= pwdata[ROW_REG_W-1:0];
               CSR_BASIS_ROW_ONE:    view.basis1 <= pwdata[ROW_REG_W-1:0];
               CSR_BASIS_ROW_TWO:    view.basis2 <= pwdata[ROW_REG_W-1:0];
               CSR_CAMERA_ORIGIN:    view.origin <= pwdata[ORG_W-1:0];
               CSR_NEAR_DISTANCE:    view.near <= pwdata[DIST_W-1:0];
               CSR_FAR_DISTANCE:     view.far <= pwdata[DIST_W-1:0];
               CSR_HALF_VIEW_WIDTH:  view.half_w <= pwdata[DIST_W-1:0];
               CSR_HALF_VIEW_HEIGHT: view.half_h <= pwdata[DIST_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            pixels_due.push_back(project(req.point_x, req.point_y, req.point_z));
         if (rsp.valid && rsp.ready) begin
            if (pixels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word vis=%0b col=%0d row=%0d",
                           rsp.visible, rsp.pixel_column, rsp.pixel_row);
            end else begin
               want = pixels_due.pop_front();
               if (rsp.visible !== want.visible || rsp.pixel_column !== want.pixel_column
                   || rsp.pixel_row !== want.pixel_row) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected vis=%0b col=%0d row=%0d,",
                               " got vis=%0b col=%0d row=%0d"},
                              want.visible, want.pixel_column, want.pixel_row,
                              rsp.visible, rsp.pixel_column, rsp.pixel_row);
               end
            end
         end
      end
      pending = pixels_due.size();
   end

endmodule

// ----- sim/tb_perspective_point_projector.sv -----
// Top of the projector testbench: clock, reset, register setup, point stimulus
// with random gaps and result stalls, watchdog and verdict.
// Depends on ppp_pkg, ppp_if, ppp_checker and the projector RTL.
module tb_perspective_point_projector;
   import ppp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;
   int mismatches, pending, idle_cycles;
   bit calm;
   int stall_left;

   ppp_req_if req ();
   ppp_rsp_if rsp ();

   perspective_point_projector dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   ppp_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .mismatches(mismatches), .pending(pending)
   );

   cfg_type view;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL perspective_point_projector");
         $finish;
      end
   end

   task automatic send_point(input logic signed [PT_W-1:0] x,
                             input logic signed [PT_W-1:0] y,
                             input logic signed [PT_W-1:0] z);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.point_x <= x;
      req.point_y <= y;
      req.point_z <= z;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'({idx, 3'b000});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   function automatic logic [47:0] rand_row();
      return 48'({$urandom_range(0, 65535), $urandom()});
   endfunction

   task automatic apply_view(input int phase);
      logic [15:0] one;
      one = 16'h4000;
      view.basis0 = {32'h0, one};
      view.basis1 = {16'h0, one, 16'h0};
      view.basis2 = {one, 32'h0};
      view.origin = {20'($signed($urandom_range(0, 4000)) - 2000),
                     20'($signed($urandom_range(0, 4000)) - 2000),
                     20'($signed($urandom_range(0, 4000)) - 2000)};
      view.near = 19'd256;
      view.far = 19'd25600;
      view.half_w = 19'd256;
      view.half_h = 19'd192;
      case (phase)
         1: begin
            view.near = 19'd1;
            view.far = 19'h7FFFF;
            view.half_w = 19'h7FFFF;
            view.half_h = 19'h7FFFF;
         end
         2: begin
            view.near = 19'h7FFFF;
            view.far = 19'h7FFFF;
            view.half_w = 19'd1;
            view.half_h = 19'd1;
         end
         3: begin
            view.basis0 = {32'h0, 16'hC000};
            view.basis2 = {16'h8000, 32'h0};
            view.near = 19'($urandom_range(1, 2000));
            view.far = 19'($urandom_range(2000, 524287));
            view.half_w = 19'($urandom_range(1, 524287));
            view.half_h = 19'($urandom_range(1, 524287));
         end
         4: begin
            view.basis0 = 48'h8000_7FFF_7FFF;
            view.basis1 = 48'h7FFF_8000_7FFF;
            view.basis2 = 48'h7FFF_7FFF_8000;
            view.origin = {20'h80000, 20'h7FFFF, 20'h80000};
         end
         5, 6: begin
            view.basis0 = rand_row();
            view.basis1 = rand_row();
            view.basis2 = rand_row();
            view.origin = 60'({$urandom(), $urandom()});
            view.near = 19'($urandom_range(1, 524287));
            view.far = 19'($urandom_range(1, 524287));
            view.half_w = 19'($urandom_range(1, 524287));
            view.half_h = 19'($urandom_range(1, 524287));
         end
         default: begin
            view.near = 19'($urandom_range(64, 1024));
            view.far = 19'($urandom_range(2048, 60000));
            view.half_w = 19'($urandom_range(16, 2048));
            view.half_h = 19'($urandom_range(16, 2048));
         end
      endcase
      csr_write(CSR_BASIS_ROW_ZERO, 64'(view.basis0));
      csr_write(CSR_BASIS_ROW_ONE, 64'(view.basis1));
      csr_write(CSR_BASIS_ROW_TWO, 64'(view.basis2));
      csr_write(CSR_CAMERA_ORIGIN, 64'(view.origin));
      csr_write(CSR_NEAR_DISTANCE, 64'(view.near));
      csr_write(CSR_FAR_DISTANCE, 64'(view.far));
      csr_write(CSR_HALF_VIEW_WIDTH, 64'(view.half_w));
      csr_write(CSR_HALF_VIEW_HEIGHT, 64'(view.half_h));
   endtask

   function automatic logic signed [PT_W-1:0] clamp_pt(input longint v);
      if (v > 524287) return 20'sd524287;
      if (v < -524288) return -20'sd524288;
      return PT_W'(v);
   endfunction

   // aim inside the frustum as seen through an identity basis
   task automatic send_aimed();
      longint n, f, dy, dx, dz, span;
      n = longint'(view.near);
      f = longint'(view.far);
      if (f < n) f = n;
      if (f > 524287) f = 524287;
      dy = n + longint'($urandom_range(0, 32'(f - n)));
      if ($urandom_range(0, 9) == 0) dy = ($urandom_range(0, 1) != 0) ? n : f;
      span = longint'(view.half_w) * dy / n;
      if (span > 524287) span = 524287;
      dx = longint'($urandom_range(0, 32'(2 * span))) - span;
      span = longint'(view.half_h) * dy / n;
      if (span > 524287) span = 524287;
      dz = longint'($urandom_range(0, 32'(2 * span))) - span;
      send_point(clamp_pt(dx + longint'($signed(view.origin[19:0]))),
                 clamp_pt(dy + longint'($signed(view.origin[39:20]))),
                 clamp_pt(dz + longint'($signed(view.origin[59:40]))));
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.point_x = '0;
      req.point_y = '0;
      req.point_z = '0;
      rsp.ready = 1'b0;
      calm = 1'b0;
      idle_cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: n 1.0, f 100.0, r 1.0, t 0.75, identity basis, origin 0
      send_point(20'sd0, 20'sd0, 20'sd0);
      send_point(20'sd0, -20'sd256, 20'sd0);
      send_point(20'sd0, 20'sd256, 20'sd0);
      send_point(20'sd256, 20'sd256, 20'sd192);
      send_point(-20'sd256, 20'sd256, -20'sd192);
      send_point(20'sd257, 20'sd256, 20'sd0);
      send_point(20'sd0, 20'sd256, 20'sd193);
      send_point(20'sd0, 20'sd255, 20'sd0);
      send_point(20'sd0, 20'sd25600, 20'sd0);
      send_point(20'sd0, 20'sd25601, 20'sd0);
      send_point(20'sd128, 20'sd512, -20'sd100);
      send_point(20'sd524287, 20'sd524287, 20'sd524287);
      send_point(-20'sd524288, -20'sd524288, -20'sd524288);
      send_point(20'sd524287, -20'sd524288, 20'sd0);
      send_point(20'sd1, 20'sd1000, -20'sd1);
      send_point(-20'sd2560, 20'sd25600, 20'sd1920);
      for (int k = 0; k < 100; k++) send_aimed();

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         apply_view(phase);
         for (int k = 0; k < 140; k++) begin
            if ($urandom_range(0, 9) < 7)
               send_aimed();
            else
               send_point(PT_W'($urandom()), PT_W'($urandom()), PT_W'($urandom()));
         end
      end

      drain();
      if (mismatches == 0 && pending == 0)
         $display("PASS perspective_point_projector");
      else
         $display("FAIL perspective_point_projector");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/ppp_pkg.sv
src/ppp_if.sv
src/ppp_csr.sv
src/ppp_ctrl.sv
src/ppp_transform.sv
src/ppp_clip.sv
src/ppp_divider.sv
src/perspective_point_projector.sv
sim/ppp_checker.sv
sim/tb_perspective_point_projector.sv
